// File: rtl/core/mtd_pkg.sv
// Shared types, character codes and the letter table of the Morse text decoder.
package mtd_pkg;

   // Character codes of the stream.
   localparam logic [7:0] CharDot     = 8'h6F;
   localparam logic [7:0] CharDash    = 8'h2D;
   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharUnknown = 8'h3F;
   localparam logic [7:0] CharA       = 8'h41;
   localparam logic [7:0] CharZ       = 8'h5A;

   // Symbol count saturates here; only the first PatternBits symbols are kept.
   localparam logic [2:0] MaxSymbols  = 3'd5;
   localparam int         PatternBits = 4;

   // Result queue geometry.
   localparam int FifoDepth = 4;
   localparam int FifoAddrW = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   typedef struct packed {
      logic [7:0] symbol_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_of_run;
   } rsp_payload_type;

   // Results of one decoded byte, handed to the result queue.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } push_type;

   // Letter for a pattern of count symbols (bit i set for a dash at symbol i).
   function automatic logic [7:0] lookup_letter(input logic [2:0] count,
                                                input logic [PatternBits-1:0] pattern,
                                                input logic bad);
      logic [7:0] letter;
      case ({count, pattern})
         {3'd2, 4'b0010}: letter = 8'h41; // A
         {3'd4, 4'b0001}: letter = 8'h42; // B
         {3'd4, 4'b0101}: letter = 8'h43; // C
         {3'd3, 4'b0001}: letter = 8'h44; // D
         {3'd1, 4'b0000}: letter = 8'h45; // E
         {3'd4, 4'b0100}: letter = 8'h46; // F
         {3'd3, 4'b0011}: letter = 8'h47; // G
         {3'd4, 4'b0000}: letter = 8'h48; // H
         {3'd2, 4'b0000}: letter = 8'h49; // I
         {3'd4, 4'b1110}: letter = 8'h4A; // J
         {3'd3, 4'b0101}: letter = 8'h4B; // K
         {3'd4, 4'b0010}: letter = 8'h4C; // L
         {3'd2, 4'b0011}: letter = 8'h4D; // M
         {3'd2, 4'b0001}: letter = 8'h4E; // N
         {3'd3, 4'b0111}: letter = 8'h4F; // O
         {3'd4, 4'b0110}: letter = 8'h50; // P
         {3'd4, 4'b1011}: letter = 8'h51; // Q
         {3'd3, 4'b0010}: letter = 8'h52; // R
         {3'd3, 4'b0000}: letter = 8'h53; // S
         {3'd1, 4'b0001}: letter = 8'h54; // T
         {3'd3, 4'b0100}: letter = 8'h55; // U
         {3'd4, 4'b1000}: letter = 8'h56; // V
         {3'd3, 4'b0110}: letter = 8'h57; // W
         {3'd4, 4'b1001}: letter = 8'h58; // X
         {3'd4, 4'b1101}: letter = 8'h59; // Y
         {3'd4, 4'b0011}: letter = 8'h5A; // Z
         default:         letter = CharUnknown;
      endcase
      // A foreign byte in the letter spoils any match.
      if (bad) begin
         letter = CharUnknown;
      end
      return letter;
   endfunction

endpackage

// File: rtl/core/morse_text_decoder_core.sv
// Path: a byte accepted into the input register is decoded from that register and its
// results are written into the result queue; the first result is offered from the queue
// entry once it is written, and the receiver may take it from there.
// Throughput: one byte per cycle, set by the single-pass decode between the input
// register and a four-entry result queue; a byte with two results gives them out one
// at a time, and input stalls when the queue cannot take two more results.
// Reset: synchronous, active high; clears the letter state and empties the queue.
module morse_text_decoder_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mtd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mtd_pkg::rsp_payload_type rsp_payload
);
   import mtd_pkg::*;

   push_type push;
   logic     queue_room;

   // Byte decode and letter state.
   mtd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_room  (queue_room),
      .push        (push)
   );

   // Result queue toward the output channel.
   mtd_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_room  (queue_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/core/mtd_decode.sv
// Input register, letter state and single-pass decode of one stream byte.
module mtd_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mtd_pkg::req_payload_type req_payload,
   input  logic                     queue_room,
   output mtd_pkg::push_type        push
);
   import mtd_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   req_payload_type        in_data_ff;
   logic [2:0]             count_ff, count_in;
   logic [PatternBits-1:0] pattern_ff, pattern_in;
   logic                   bad_ff, bad_in;

   logic                   accept, advance;
   logic                   is_dot, is_dash, is_slash, is_space, is_symbol;
   logic [2:0]             count_upd;
   logic [PatternBits-1:0] pattern_upd;
   logic                   bad_upd;
   logic [7:0]             letter;
   logic                   eom;

   // The held byte moves on once the result queue has room for two results.
   assign advance   = in_valid_ff & queue_room;
   assign req_stall = in_valid_ff & ~queue_room;
   assign accept    = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~advance);

   // Byte classification.
   always_comb begin
      is_dot    = (in_data_ff.symbol_byte == CharDot);
      is_dash   = (in_data_ff.symbol_byte == CharDash);
      is_slash  = (in_data_ff.symbol_byte == CharSlash);
      is_space  = (in_data_ff.symbol_byte == CharSpace);
      is_symbol = ~is_slash & ~is_space;
      eom       = in_data_ff.end_of_message;
   end

   // Letter state with this byte added as a symbol.
   always_comb begin
      count_upd   = (count_ff < MaxSymbols) ? count_ff + 3'd1 : count_ff;
      pattern_upd = pattern_ff;
      if (is_dash && count_ff < 3'(PatternBits)) begin
         pattern_upd = pattern_ff | (PatternBits'(1) << count_ff[1:0]);
      end
      bad_upd = bad_ff | ~(is_dot | is_dash);
   end

   // A separator decodes the letter so far; a symbol with the end flag decodes
   // the letter including itself.
   always_comb begin
      if (is_symbol) begin
         letter = lookup_letter(count_upd, pattern_upd, bad_upd);
      end else begin
         letter = lookup_letter(count_ff, pattern_ff, bad_ff);
      end
   end

   // Results of the held byte.
   always_comb begin
      push.count              = 2'd0;
      push.first.text_char    = letter;
      push.first.last_of_run  = 1'b1;
      push.second.text_char   = CharSpace;
      push.second.last_of_run = 1'b1;
      if (is_slash) begin
         push.count = (count_ff != 3'd0) ? 2'd1 : 2'd0;
      end else if (is_space) begin
         if (count_ff != 3'd0) begin
            push.count             = 2'd2;
            push.first.last_of_run = 1'b0;
         end else begin
            push.count           = 2'd1;
            push.first.text_char = CharSpace;
         end
      end else begin
         push.count = eom ? 2'd1 : 2'd0;
      end
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   // Next letter state: separators and the end flag clear it.
   always_comb begin
      count_in   = count_ff;
      pattern_in = pattern_ff;
      bad_in     = bad_ff;
      if (advance) begin
         if (is_symbol && !eom) begin
            count_in   = count_upd;
            pattern_in = pattern_upd;
            bad_in     = bad_upd;
         end else begin
            count_in   = 3'd0;
            pattern_in = '0;
            bad_in     = 1'b0;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= 3'd0;
         pattern_ff  <= '0;
         bad_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         pattern_ff  <= pattern_in;
         bad_ff      <= bad_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_payload;
      end
   end

endmodule

// File: rtl/core/mtd_result_fifo.sv
// Small result queue that takes up to two results per cycle and gives one while the receiver does not stall.
module mtd_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  mtd_pkg::push_type        push,
   output logic                     queue_room,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mtd_pkg::rsp_payload_type rsp_payload
);
   import mtd_pkg::*;

   rsp_payload_type        entry_ff [FifoDepth];
   logic [FifoAddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoAddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]    count_ff, count_in;
   logic [FifoAddrW-1:0]   wr_next;
   logic                   pop;

   // Room for the worst case of two results, regardless of a pop this cycle.
   assign queue_room  = (count_ff <= FifoCntW'(FifoDepth - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid & ~rsp_stall;
   assign wr_next     = wr_ptr_ff + FifoAddrW'(1);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoAddrW'(push.count);
      rd_ptr_in = rd_ptr_ff + FifoAddrW'(pop);
      count_in  = count_ff + FifoCntW'(push.count) - FifoCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry writes: first result at the write pointer, second one after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// File: rtl/core/mtd_checker.sv
// Port-level checks of the Morse text decoder and their binding to the top level.
module mtd_assertions (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input mtd_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input mtd_pkg::rsp_payload_type rsp_payload
);
   import mtd_pkg::*;

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // A stalled request transaction stays offered with the same payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed or dropped");

   // Reset leaves nothing pending and the input open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // A space always closes the results of its byte.
   a_space_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.text_char == CharSpace |-> rsp_payload.last_of_run)
      else $error("space result not marked last");

   // Only letters, the unknown mark and a space come out.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.text_char == CharSpace
                 || rsp_payload.text_char == CharUnknown
                 || (rsp_payload.text_char >= CharA && rsp_payload.text_char <= CharZ))
      else $error("unexpected result character");

endmodule

bind morse_text_decoder_core mtd_assertions u_mtd_assertions (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// File: verif/mtd_checker.sv
// Result checker for the Morse text decoder: predicts decoded text and compares each result.
module mtd_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  mtd_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  mtd_pkg::rsp_payload_type rsp_payload,
   output int                       fail_count,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import mtd_pkg::*;

   // Letter being gathered, as seen by the predictor.
   logic [2:0] letter_len;
   logic [3:0] dash_bits;
   logic       foreign_seen;

   // Decoded characters still owed by the block, oldest first.
   rsp_payload_type expected_chars[$];

   // Look the letter up in the dot and dash code list, one letter per word.
   function automatic logic [7:0] decode_letter(input logic [2:0] count,
                                                input logic [3:0] pattern,
                                                input logic foreign);
      string      codes;
      int         letter_idx;
      int         code_len;
      logic [3:0] code_bits;
      logic [7:0] found;
      codes = {"o- -ooo -o-o -oo o oo-o --o oooo oo o--- -o- o-oo -- -o --- ",
               "o--o --o- o-o ooo - oo- ooo- o-- -oo- -o-- --oo "};
      found = CharUnknown;
      letter_idx = 0;
      code_len = 0;
      code_bits = '0;
      if (!foreign && count != 3'd0 && count <= 3'd4) begin
         for (int i = 0; i < codes.len(); i++) begin
            if (codes[i] == " ") begin
               if (code_len == count && code_bits == pattern) begin
                  found = CharA + 8'(letter_idx);
               end
               letter_idx++;
               code_len = 0;
               code_bits = '0;
            end else begin
               if (codes[i] == "-") begin
                  code_bits[code_len] = 1'b1;
               end
               code_len++;
            end
         end
      end
      return found;
   endfunction

   // Advance the letter state by one byte and queue the characters it produces.
   function automatic void decode_byte(input req_payload_type item);
      logic [7:0]      chars [2];
      int              n;
      rsp_payload_type entry;
      n = 0;
      if (item.symbol_byte == CharSlash) begin
         if (letter_len != 3'd0) begin
            chars[n] = decode_letter(letter_len, dash_bits, foreign_seen);
            n++;
         end
         letter_len = '0;
         dash_bits = '0;
         foreign_seen = 1'b0;
      end else if (item.symbol_byte == CharSpace) begin
         if (letter_len != 3'd0) begin
            chars[n] = decode_letter(letter_len, dash_bits, foreign_seen);
            n++;
         end
         letter_len = '0;
         dash_bits = '0;
         foreign_seen = 1'b0;
         chars[n] = CharSpace;
         n++;
      end else begin
         // Only the first four symbols are kept; anything but a dot or dash spoils the letter.
         if (item.symbol_byte == CharDash) begin
            if (letter_len < 3'd4) begin
               dash_bits[letter_len[1:0]] = 1'b1;
            end
         end else if (item.symbol_byte != CharDot) begin
            foreign_seen = 1'b1;
         end
         if (letter_len < MaxSymbols) begin
            letter_len = letter_len + 3'd1;
         end
      end

      // End of message flushes whatever letter is still pending.
      if (item.end_of_message) begin
         if (letter_len != 3'd0) begin
            chars[n] = decode_letter(letter_len, dash_bits, foreign_seen);
            n++;
         end
         letter_len = '0;
         dash_bits = '0;
         foreign_seen = 1'b0;
      end

      for (int k = 0; k < n; k++) begin
         entry.text_char = chars[k];
         entry.last_of_run = (k == n - 1);
         expected_chars.push_back(entry);
      end
   endfunction

   // Compare each result transaction with the oldest prediction, then absorb new input.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         letter_len = '0;
         dash_bits = '0;
         foreign_seen = 1'b0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected result: text_char %h last_of_run %b",
                      rsp_payload.text_char, rsp_payload.last_of_run);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_payload.text_char !== want.text_char) begin
                  $error("text_char: expected %h, got %h",
                         want.text_char, rsp_payload.text_char);
                  fail_count++;
               end
               if (rsp_payload.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b",
                         want.last_of_run, rsp_payload.last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_payload);
         end
      end
      outstanding <= expected_chars.size();
   end

endmodule

// File: verif/tb.sv
// Testbench top for the Morse text decoder: clock, reset, byte stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mtd_pkg::*;

   localparam int QuietLimit  = 2000;
   localparam int PhaseItems  = 375;
   localparam int HeavyPct    = 82;
   localparam int LightPct    = 19;
   localparam int SettleTicks = 20;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int          fail_count;
   int          outstanding;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   morse_text_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   mtd_checker text_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one byte, with an optional idle gap first, and wait until it is taken.
   task automatic send_byte(input logic [7:0] sym, input logic eom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload.symbol_byte <= sym;
      req_payload.end_of_message <= eom;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input string text, input logic eom_last);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], eom_last && (i == text.len() - 1));
      end
   endtask

   // One word of random letters; some letters run long or carry a foreign byte.
   task automatic send_word();
      int         letters;
      int         sym_count;
      int         ending;
      logic [7:0] sym;
      letters = $urandom_range(1, 5);
      for (int l = 0; l < letters; l++) begin
         sym_count = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
         for (int s = 0; s < sym_count; s++) begin
            if ($urandom_range(39) == 0) begin
               sym = 8'($urandom_range(255));
            end else begin
               sym = $urandom_range(1) ? CharDash : CharDot;
            end
            send_byte(sym, $urandom_range(49) == 0);
         end
         if (l < letters - 1) begin
            send_byte(CharSlash, $urandom_range(49) == 0);
         end
      end
      ending = $urandom_range(3);
      if (ending == 0) begin
         send_byte(CharSlash, 1'b0);
         send_byte(CharSpace, $urandom_range(9) == 0);
      end else if (ending == 3) begin
         send_byte(CharSlash, 1'b1);
      end else begin
         send_byte(CharSpace, $urandom_range(9) == 0);
      end
   endtask

   // Mostly well-formed words, with a share of arbitrary bytes as noise.
   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      int target;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      target = bytes_sent + PhaseItems;
      while (bytes_sent < target) begin
         if ($urandom_range(9) == 0) begin
            send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
         end else begin
            send_word();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: table ends, empty letter and word, foreign bytes, long letter, end flag.
      send_text("o-/", 1'b0);
      send_text("--oo/", 1'b0);
      send_text("/", 1'b0);
      send_text(" ", 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("/", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text(" ", 1'b0);
      send_text("----- ", 1'b1);
      send_text("/", 1'b1);
      send_text("-", 1'b1);
      send_text("o/", 1'b1);

      run_phase(0, 0);
      run_phase(HeavyPct, 0);
      run_phase(0, HeavyPct);
      run_phase(LightPct, LightPct);
      req_valid <= 1'b0;

      // Drain the remaining results, then watch a little longer for strays.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      recv_stall_pct = 0;
      repeat (SettleTicks) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: morse_text_decoder_core.f
rtl/core/mtd_pkg.sv
rtl/core/mtd_decode.sv
rtl/core/mtd_result_fifo.sv
rtl/core/morse_text_decoder_core.sv
rtl/core/mtd_checker.sv
verif/mtd_checker.sv
verif/tb.sv
